// ===== hdl/npc_pkg.sv =====
package npc_pkg;

   // field widths fixed by the interface
   localparam int COLOR_W        = 8;
   localparam int INDEX_W        = 8;
   localparam int SQ_W           = 2 * COLOR_W;
   localparam int DIST_W         = SQ_W + 2;

   localparam int PALETTE_ENTRIES_DEFAULT = 256;

   // request command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // write one palette entry
      logic capture;  // latch query color, start of a search
      logic issue;    // read one palette entry into the pipeline
      logic last;     // the issued entry is the final one
   } npc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;     // final entry is being compared this cycle
   } npc_status_type;

   function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

// ===== hdl/nearest_palette_color.sv =====
// nearest palette color search
//
//   channel   ports                                         handshake
//   request   req_cmd req_entry_index req_red/green/blue    start && !busy
//   result    rsp_color_index                               rsp_valid, one cycle
//
// a load request writes one palette entry and is done in the accepting cycle;
// busy stays low, so another request can follow at once
// a query walks the palette one entry per cycle through the single memory read
// port, then three pipeline stages (read, square, sum) and the min compare:
// rsp_valid is registered from the final entry's arrival at the min compare
// busy is high from the cycle after a query is accepted until rsp_valid
// reset clears the controller, pipeline flags and every palette valid bit at once,
// so the palette reads as black right after reset; no clearing pass
// the result strobe cannot be held off by the receiver

module nearest_palette_color #(
   parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic [npc_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [npc_pkg::COLOR_W-1:0]   req_red,
   input  logic [npc_pkg::COLOR_W-1:0]   req_green,
   input  logic [npc_pkg::COLOR_W-1:0]   req_blue,

   // result channel
   output logic                          rsp_valid,
   output logic [npc_pkg::INDEX_W-1:0]   rsp_color_index
);

   // at least one address bit, even for a single-entry palette
   localparam int ADDR_W = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;

   npc_pkg::npc_cmd_type    cmd;
   npc_pkg::npc_status_type status;
   npc_pkg::rgb_type        req_color;
   logic [ADDR_W-1:0]       scan_addr;
   logic [ADDR_W-1:0]       load_addr;

   // request color doubles as palette write data and query color
   assign req_color = '{red: req_red, green: req_green, blue: req_blue};

   // sequencing: accepts requests, steps the scan address, waits for the drain
   npc_ctrl #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .ADDR_W          (ADDR_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .busy            (busy),
      .cmd             (cmd),
      .status          (status),
      .scan_addr       (scan_addr),
      .load_addr       (load_addr)
   );

   // palette memory, distance pipeline and running minimum
   npc_datapath #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .ADDR_W          (ADDR_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .scan_addr       (scan_addr),
      .load_addr       (load_addr),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_color_index (rsp_color_index)
   );

endmodule

// ===== hdl/npc_datapath.sv =====
module npc_datapath #(
   parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEFAULT,
   parameter int ADDR_W          = $clog2(PALETTE_ENTRIES)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  npc_pkg::npc_cmd_type         cmd,
   output npc_pkg::npc_status_type      status,
   input  logic [ADDR_W-1:0]            scan_addr,
   input  logic [ADDR_W-1:0]            load_addr,
   input  npc_pkg::rgb_type             req_color,
   output logic                         rsp_valid,
   output logic [npc_pkg::INDEX_W-1:0]  rsp_color_index
);

   // palette memory plus per-entry valid bits (unwritten entries read as black)
   npc_pkg::rgb_type            mem_ff [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0]  written_ff;

   npc_pkg::rgb_type            query_ff;

   // stage 1: registered memory read
   npc_pkg::rgb_type            s1_data_ff;
   logic                        s1_written_ff;
   logic                        s1_vld_ff;
   logic                        s1_last_ff;
   logic [ADDR_W-1:0]           s1_idx_ff;

   // stage 2: squared channel differences
   logic [npc_pkg::SQ_W-1:0]    s2_sq_r_ff, s2_sq_g_ff, s2_sq_b_ff;
   logic [npc_pkg::SQ_W-1:0]    s2_sq_r_in, s2_sq_g_in, s2_sq_b_in;
   logic                        s2_vld_ff;
   logic                        s2_last_ff;
   logic [ADDR_W-1:0]           s2_idx_ff;

   // stage 3: distance
   logic [npc_pkg::DIST_W-1:0]  s3_dist_ff;
   logic                        s3_vld_ff;
   logic                        s3_last_ff;
   logic [ADDR_W-1:0]           s3_idx_ff;

   // running minimum
   logic [npc_pkg::DIST_W-1:0]  best_dist_ff;
   logic [ADDR_W-1:0]           best_idx_ff;
   logic                        best_take;
   logic                        done_ff;

   npc_pkg::rgb_type            s1_color;
   logic [npc_pkg::COLOR_W-1:0] d_r, d_g, d_b;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mem_ff[load_addr] <= req_color;
      end
      s1_data_ff <= mem_ff[scan_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         s1_written_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            written_ff[load_addr] <= 1'b1;
         end
         s1_written_ff <= written_ff[scan_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         query_ff <= req_color;
      end
   end

   assign s1_color = s1_written_ff ? s1_data_ff : '0;

   always_comb begin
      d_r        = npc_pkg::abs_diff(s1_color.red,   query_ff.red);
      d_g        = npc_pkg::abs_diff(s1_color.green, query_ff.green);
      d_b        = npc_pkg::abs_diff(s1_color.blue,  query_ff.blue);
      s2_sq_r_in = npc_pkg::SQ_W'(d_r) * npc_pkg::SQ_W'(d_r);
      s2_sq_g_in = npc_pkg::SQ_W'(d_g) * npc_pkg::SQ_W'(d_g);
      s2_sq_b_in = npc_pkg::SQ_W'(d_b) * npc_pkg::SQ_W'(d_b);
   end

   // pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         done_ff   <= s3_vld_ff & s3_last_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      s1_last_ff <= cmd.last;
      s1_idx_ff  <= scan_addr;

      s2_sq_r_ff <= s2_sq_r_in;
      s2_sq_g_ff <= s2_sq_g_in;
      s2_sq_b_ff <= s2_sq_b_in;
      s2_last_ff <= s1_last_ff;
      s2_idx_ff  <= s1_idx_ff;

      s3_dist_ff <= npc_pkg::DIST_W'(s2_sq_r_ff) + npc_pkg::DIST_W'(s2_sq_g_ff)
                  + npc_pkg::DIST_W'(s2_sq_b_ff);
      s3_last_ff <= s2_last_ff;
      s3_idx_ff  <= s2_idx_ff;
   end

   // entry zero opens a new search; strict less-than keeps the lowest index on ties
   assign best_take = s3_vld_ff & ((s3_idx_ff == '0) | (s3_dist_ff < best_dist_ff));

   always_ff @(posedge clock) begin
      if (best_take) begin
         best_dist_ff <= s3_dist_ff;
         best_idx_ff  <= s3_idx_ff;
      end
   end

   assign status.done     = s3_vld_ff & s3_last_ff;
   assign rsp_valid       = done_ff;
   assign rsp_color_index = npc_pkg::INDEX_W'(best_idx_ff);

endmodule

// ===== hdl/npc_ctrl.sv =====
module npc_ctrl #(
   parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEFAULT,
   parameter int ADDR_W          = $clog2(PALETTE_ENTRIES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          req_cmd,
   input  logic [npc_pkg::INDEX_W-1:0]   req_entry_index,
   output logic                          busy,
   output npc_pkg::npc_cmd_type          cmd,
   input  npc_pkg::npc_status_type       status,
   output logic [ADDR_W-1:0]             scan_addr,
   output logic [ADDR_W-1:0]             load_addr
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic              accept;
   logic              in_range;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start & ~busy;
   assign in_range = ({1'b0, req_entry_index} < (npc_pkg::INDEX_W + 1)'(PALETTE_ENTRIES));

   always_comb begin
      state_in     = state_ff;
      scan_addr_in = scan_addr_ff;
      cmd          = '0;
      cmd.load     = accept & (req_cmd == npc_pkg::CMD_LOAD) & in_range;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_cmd == npc_pkg::CMD_QUERY) begin
               cmd.capture  = 1'b1;
               scan_addr_in = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            cmd.last  = (scan_addr_ff == LAST_ADDR);
            if (cmd.last) begin
               state_in = ST_DRAIN;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (status.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_addr_ff <= '0;
      end else begin
         state_ff     <= state_in;
         scan_addr_ff <= scan_addr_in;
      end
   end

   assign scan_addr = scan_addr_ff;
   assign load_addr = req_entry_index[ADDR_W-1:0];

`ifndef ASSERT_OFF
   a_capture_starts_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_SCAN) && (scan_addr_ff == '0))
      else $error("search did not start at entry zero");

   a_scan_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && !cmd.last |=>
         (state_ff == ST_SCAN) && (scan_addr_ff == ADDR_W'($past(scan_addr_ff) + 1'b1)))
      else $error("scan address skipped an entry");

   a_done_while_drain: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (state_ff == ST_DRAIN))
      else $error("search finished outside drain");

   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == ST_IDLE) && !cmd.issue)
      else $error("palette write during a search");
`endif

endmodule

// ===== test/tb_nearest_palette_color.sv =====
module tb_nearest_palette_color;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEFAULT;
   localparam int RANDOM_REQUESTS = 1530;
   localparam int IDLE_PERCENT    = 17;
   // a query holds the block busy for a whole palette scan and drain with nothing accepted
   localparam int STALL_LIMIT     = 8 * (PALETTE_ENTRIES + 16);
   localparam int DRAIN_CYCLES    = PALETTE_ENTRIES + 16;
   localparam int REPORT_LIMIT    = 10;

   // one request as queued for the driver
   typedef struct {
      logic                         cmd;
      logic [npc_pkg::INDEX_W-1:0]  entry_index;
      npc_pkg::rgb_type             color;
   } palette_request_type;

   // one outstanding query and the index it must return
   typedef struct {
      npc_pkg::rgb_type             color;
      logic [npc_pkg::INDEX_W-1:0]  index;
   } color_lookup_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic                         req_cmd = npc_pkg::CMD_LOAD;
   logic [npc_pkg::INDEX_W-1:0]  req_entry_index = '0;
   logic [npc_pkg::COLOR_W-1:0]  req_red = '0;
   logic [npc_pkg::COLOR_W-1:0]  req_green = '0;
   logic [npc_pkg::COLOR_W-1:0]  req_blue = '0;
   logic                         rsp_valid;
   logic [npc_pkg::INDEX_W-1:0]  rsp_color_index;

   palette_request_type  pending_requests[$];
   color_lookup_type     expected_lookups[$];
   npc_pkg::rgb_type     palette_shadow[PALETTE_ENTRIES];
   npc_pkg::rgb_type     stim_palette[PALETTE_ENTRIES];
   int                   accepted_count = 0;
   int                   mismatch_count = 0;
   int                   stall_cycles = 0;

   nearest_palette_color #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_color_index (rsp_color_index)
   );

   always #4ns clock = ~clock;

   // ---------------------------------------------------------------------------
   // predictor: shadow palette and nearest-entry search
   // ---------------------------------------------------------------------------

   // lowest index with the smallest squared rgb distance
   function automatic logic [npc_pkg::INDEX_W-1:0] nearest_entry(npc_pkg::rgb_type color);
      int                           best_dist;
      int                           sq_dist;
      int                           dr;
      int                           dg;
      int                           db;
      logic [npc_pkg::INDEX_W-1:0]  best_index;
      best_dist  = 32'h7FFF_FFFF;
      best_index = '0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         dr      = int'(palette_shadow[i].red)   - int'(color.red);
         dg      = int'(palette_shadow[i].green) - int'(color.green);
         db      = int'(palette_shadow[i].blue)  - int'(color.blue);
         sq_dist = dr * dr + dg * dg + db * db;
         // strict compare keeps the first entry on a tie
         if (sq_dist < best_dist) begin
            best_dist  = sq_dist;
            best_index = npc_pkg::INDEX_W'(i);
         end
      end
      return best_index;
   endfunction

   // apply one accepted request to the shadow palette or queue its answer
   function automatic void apply_request(logic cmd, logic [npc_pkg::INDEX_W-1:0] entry_index,
                                         npc_pkg::rgb_type color);
      color_lookup_type lookup;
      if (cmd == npc_pkg::CMD_LOAD) begin
         // loads past the palette size are dropped
         if (int'(entry_index) < PALETTE_ENTRIES) begin
            palette_shadow[entry_index] = color;
         end
      end else begin
         lookup.color = color;
         lookup.index = nearest_entry(color);
         expected_lookups.push_back(lookup);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   task automatic add_request(logic cmd, logic [npc_pkg::INDEX_W-1:0] entry_index,
                              logic [npc_pkg::COLOR_W-1:0] red,
                              logic [npc_pkg::COLOR_W-1:0] green,
                              logic [npc_pkg::COLOR_W-1:0] blue);
      palette_request_type request;
      request.cmd         = cmd;
      request.entry_index = entry_index;
      request.color.red   = red;
      request.color.green = green;
      request.color.blue  = blue;
      // stimulus keeps its own view of the palette to aim queries at loaded colors
      if (cmd == npc_pkg::CMD_LOAD && int'(entry_index) < PALETTE_ENTRIES) begin
         stim_palette[entry_index] = request.color;
      end
      pending_requests.push_back(request);
   endtask

   // move a channel a few steps, saturating at the ends
   function automatic logic [npc_pkg::COLOR_W-1:0] nudge(logic [npc_pkg::COLOR_W-1:0] channel);
      int moved;
      moved = int'(channel) + $urandom_range(12) - 6;
      if (moved < 0) begin
         moved = 0;
      end else if (moved > 255) begin
         moved = 255;
      end
      return npc_pkg::COLOR_W'(moved);
   endfunction

   // ---------------------------------------------------------------------------
   // driver: one request on the ports at a time, random idle cycles
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin : request_driver
      palette_request_type  next_request;
      logic                 idling_on;
      logic                 take_next;
      if (reset) begin
         start <= 1'b0;
      end else begin
         // request on the ports is taken at this edge
         if (start && !busy) begin
            apply_request(req_cmd, req_entry_index, '{req_red, req_green, req_blue});
            accepted_count++;
         end
         // a long stretch in the middle of the run with no idle cycles
         idling_on = !(accepted_count >= 700 && accepted_count < 1000);
         take_next = !start || !busy;
         if (take_next) begin
            if (pending_requests.size() > 0 &&
                !(idling_on && $urandom_range(99) < IDLE_PERCENT)) begin
               next_request    = pending_requests.pop_front();
               start           <= 1'b1;
               req_cmd         <= next_request.cmd;
               req_entry_index <= next_request.entry_index;
               req_red         <= next_request.color.red;
               req_green       <= next_request.color.green;
               req_blue        <= next_request.color.blue;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: every result strobe is checked against the oldest query
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin : result_monitor
      color_lookup_type lookup;
      if (!reset && rsp_valid) begin
         if (expected_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected result: color_index %0d with no query pending",
                        rsp_color_index);
            end
         end else begin
            lookup = expected_lookups.pop_front();
            if (rsp_color_index !== lookup.index) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: query rgb %h %h %h expected index %0d got %0d",
                           lookup.color.red, lookup.color.green, lookup.color.blue,
                           lookup.index, rsp_color_index);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: too long with neither a request nor a result accepted
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin : stall_watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------------------

   initial begin
      int                           pick;
      int                           kind;
      logic [npc_pkg::INDEX_W-1:0]  entry_index;
      npc_pkg::rgb_type             color;

      foreach (palette_shadow[i]) begin
         palette_shadow[i] = '0;
         stim_palette[i]   = '0;
      end

      // directed part
      // palette all black after reset: every entry ties, lowest index wins
      add_request(npc_pkg::CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
      add_request(npc_pkg::CMD_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      // top entry white, exact and near matches
      add_request(npc_pkg::CMD_LOAD,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_request(npc_pkg::CMD_QUERY, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      add_request(npc_pkg::CMD_QUERY, 8'h5A, 8'hC8, 8'hC8, 8'hC8);
      // entry zero no longer black: black now found at entry one
      add_request(npc_pkg::CMD_LOAD,  8'h00, 8'hFF, 8'h00, 8'h00);
      add_request(npc_pkg::CMD_QUERY, 8'hA5, 8'h00, 8'h00, 8'h00);
      add_request(npc_pkg::CMD_QUERY, 8'h3C, 8'hF0, 8'h10, 8'h10);
      // same color at two entries: lower one wins
      add_request(npc_pkg::CMD_LOAD,  8'h80, 8'h01, 8'h02, 8'h03);
      add_request(npc_pkg::CMD_LOAD,  8'h07, 8'h01, 8'h02, 8'h03);
      add_request(npc_pkg::CMD_QUERY, 8'hC3, 8'h01, 8'h02, 8'h03);
      // pure primaries
      add_request(npc_pkg::CMD_LOAD,  8'h01, 8'h00, 8'hFF, 8'h00);
      add_request(npc_pkg::CMD_LOAD,  8'h02, 8'h00, 8'h00, 8'hFF);
      add_request(npc_pkg::CMD_QUERY, 8'h01, 8'h00, 8'hFF, 8'h00);
      add_request(npc_pkg::CMD_QUERY, 8'h02, 8'h00, 8'h00, 8'hFF);
      // alternating bit patterns
      add_request(npc_pkg::CMD_LOAD,  8'hAA, 8'hAA, 8'h55, 8'hAA);
      add_request(npc_pkg::CMD_LOAD,  8'h55, 8'h55, 8'hAA, 8'h55);
      add_request(npc_pkg::CMD_QUERY, 8'hAA, 8'h55, 8'hAA, 8'h55);
      add_request(npc_pkg::CMD_QUERY, 8'h55, 8'hA0, 8'h50, 8'hA0);
      // equidistant between two loaded colors with no exact match
      add_request(npc_pkg::CMD_LOAD,  8'h40, 8'h80, 8'h80, 8'h70);
      add_request(npc_pkg::CMD_LOAD,  8'h30, 8'h80, 8'h80, 8'h90);
      add_request(npc_pkg::CMD_QUERY, 8'h77, 8'h80, 8'h80, 8'h80);

      // random part: mostly loads to fill the palette, queries mostly aimed at it, some random
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         pick        = $urandom_range(99);
         entry_index = npc_pkg::INDEX_W'($urandom_range(255));
         if (pick < 65) begin
            if ($urandom_range(99) < 15) begin
               // duplicate another entry's color to make ties
               color = stim_palette[$urandom_range(PALETTE_ENTRIES - 1)];
            end else begin
               color = npc_pkg::rgb_type'($urandom);
            end
            add_request(npc_pkg::CMD_LOAD, entry_index, color.red, color.green, color.blue);
         end else begin
            kind = $urandom_range(2);
            if (kind == 0) begin
               color = npc_pkg::rgb_type'($urandom);
            end else begin
               color = stim_palette[$urandom_range(PALETTE_ENTRIES - 1)];
               if (kind == 2) begin
                  color.red   = nudge(color.red);
                  color.green = nudge(color.green);
                  color.blue  = nudge(color.blue);
               end
            end
            add_request(npc_pkg::CMD_QUERY, entry_index, color.red, color.green, color.blue);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // all requests taken and all answers in
      do begin
         @(negedge clock);
      end while (pending_requests.size() > 0 || start || expected_lookups.size() > 0);

      // room for any stray result strobe
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
